/* sv/ugim_pkg.sv */
`timescale 1ns / 1ps

package ugim_pkg;

  // field widths
  localparam int unsigned CP_W       = 21;
  localparam int unsigned GLYPH_W    = 16;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned RC_W       = 7;
  localparam int unsigned SIZE_W     = 23;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // default number of range cells
  localparam int unsigned MAX_RANGES_DEF = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_TOTAL = 1'b1;

  // input word kinds
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // utf-8 lead byte patterns
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
  localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'h80;

  // token moving down the cell chain: a table load or a lookup
  // for a lookup, lo holds the code point
  typedef struct packed {
    logic               vld;
    logic               load;
    logic [SLOT_W-1:0]  slot;
    logic [CP_W-1:0]    lo;
    logic [CP_W-1:0]    hi;
    logic               bad;
    logic               done;
    logic               found;
    logic [GLYPH_W-1:0] glyph;
  } tok_t;

endpackage

/* sv/ugim_decoder.sv */
`timescale 1ns / 1ps

module ugim_decoder import ugim_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              accept_i,
  input  logic              opcode_i,
  input  logic [BYTE_W-1:0] text_byte_i,
  input  logic [SLOT_W-1:0] range_slot_i,
  input  logic [CP_W-1:0]   range_first_i,
  input  logic [CP_W-1:0]   range_last_i,
  output tok_t              tok_o
);

  logic [1:0]      pend_q, pend_d;
  logic [CP_W-1:0] part_q, part_d;
  logic [CP_W-1:0] part_n;
  tok_t            tok_q, tok_d;

  assign part_n = {part_q[CP_W-7:0], text_byte_i[5:0] & CONT_BITS[5:0]};

  // decode one byte, emit a load, a finished code point or a bad lead mark
  always_comb begin
    pend_d = pend_q;
    part_d = part_q;
    tok_d  = tok_q;
    if (adv_i) begin
      tok_d = '0;
      if (accept_i) begin
        if (opcode_i == OP_LOAD) begin
          tok_d.vld  = 1'b1;
          tok_d.load = 1'b1;
          tok_d.slot = range_slot_i;
          tok_d.lo   = range_first_i;
          tok_d.hi   = range_last_i;
        end else if (pend_q != 2'd0) begin
          part_d = part_n;
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            tok_d.vld = 1'b1;
            tok_d.lo  = part_n;
          end
        end else if (text_byte_i < ASCII_LIM) begin
          tok_d.vld = 1'b1;
          tok_d.lo  = {{(CP_W-BYTE_W){1'b0}}, text_byte_i};
        end else if ((text_byte_i & LEAD2_MASK) == LEAD2_VAL) begin
          part_d = {{(CP_W-BYTE_W){1'b0}}, text_byte_i & LEAD2_BITS};
          pend_d = 2'd1;
        end else if ((text_byte_i & LEAD3_MASK) == LEAD3_VAL) begin
          part_d = {{(CP_W-BYTE_W){1'b0}}, text_byte_i & LEAD3_BITS};
          pend_d = 2'd2;
        end else if ((text_byte_i & LEAD4_MASK) == LEAD4_VAL) begin
          part_d = {{(CP_W-BYTE_W){1'b0}}, text_byte_i & LEAD4_BITS};
          pend_d = 2'd3;
        end else begin
          tok_d.vld = 1'b1;
          tok_d.bad = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= '0;
      tok_q  <= '0;
    end else begin
      pend_q <= pend_d;
      part_q <= part_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* sv/ugim_cell.sv */
`timescale 1ns / 1ps

module ugim_cell import ugim_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned OFS_W = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic [RC_W-1:0]         range_count_i,
  input  logic [GLYPH_W-1:0]      glyph_total_i,
  input  tok_t                    tok_i,
  input  logic signed [OFS_W-1:0] ofs_i,
  output tok_t                    tok_o,
  output logic signed [OFS_W-1:0] ofs_o
);

  localparam logic [31:0] IDX32 = IDX;

  // range held by this cell, undefined until loaded
  logic [CP_W-1:0]          first_q, last_q;
  logic signed [SIZE_W-1:0] size_q;
  logic signed [SIZE_W-1:0] size_d;

  tok_t                    tok_q, tok_d;
  logic signed [OFS_W-1:0] ofs_q, ofs_d;

  logic                    slot_hit, active, hit, idx_ok;
  logic [CP_W-1:0]         diff;
  logic signed [OFS_W-1:0] idx;

  assign slot_hit = ({{(32-SLOT_W){1'b0}}, tok_i.slot} == IDX32);
  assign active   = ({{(32-RC_W){1'b0}}, range_count_i} > IDX32);
  assign hit      = (tok_i.lo >= first_q) && (tok_i.lo <= last_q);
  assign diff     = tok_i.lo - first_q;
  assign idx      = ofs_i + $signed({{(OFS_W-CP_W){1'b0}}, diff});
  assign idx_ok   = !idx[OFS_W-1] &&
                    (idx < $signed({{(OFS_W-GLYPH_W){1'b0}}, glyph_total_i}));
  assign size_d   = $signed({2'b00, tok_i.hi}) - $signed({2'b00, tok_i.lo}) +
                    $signed({{(SIZE_W-1){1'b0}}, 1'b1});

  // lookup step: match or add this range's size to the offset
  always_comb begin
    tok_d = tok_i;
    ofs_d = ofs_i;
    if (tok_i.vld && !tok_i.load && !tok_i.done && active) begin
      if (hit) begin
        tok_d.done  = 1'b1;
        tok_d.found = idx_ok;
        tok_d.glyph = idx_ok ? idx[GLYPH_W-1:0] : '0;
      end else begin
        ofs_d = ofs_i + {{(OFS_W-SIZE_W){size_q[SIZE_W-1]}}, size_q};
      end
    end
  end

  // table storage, written when a load for this slot passes
  always_ff @(posedge clk_i) begin
    if (adv_i && tok_i.vld && tok_i.load && slot_hit) begin
      first_q <= tok_i.lo;
      last_q  <= tok_i.hi;
      size_q  <= size_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      ofs_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      ofs_q <= ofs_d;
    end
  end

  assign tok_o = tok_q;
  assign ofs_o = ofs_q;

endmodule

/* sv/utf8_glyph_index_mapper.sv */
`timescale 1ns / 1ps

// utf-8 decoder with glyph index lookup
// input words (s_axis): tuser is the word kind, 0 for a text byte, 1 for a
// range table load. a text byte steps the decoder; a load writes one slot.
// output words (m_axis): one per completed character or invalid lead byte,
// carrying the code point, glyph index, found flag and bad lead flag.
// loads give no output word.
// config port: range_count (index 0) and glyph total (index 1), to be written
// by the user only while the block is idle; the block itself does not enforce it.
// an output word passes from the decoder register, which loads at the edge
// that accepts the byte completing the character, through one register per
// range cell to the output register.
// throughput: one input word per cycle while the output is not stalled; every word,
// loads too, travels the chain of range cells so loads and lookups stay in order.
// reset clears the decoder, the chain, the output valid flag and both config registers;
// table slots stay undefined until loaded.
// when the receiver stalls with an output word waiting, the whole chain
// holds and s_axis_tready_o drops until the word is taken.
module utf8_glyph_index_mapper import ugim_pkg::*; #(
  parameter int unsigned MAX_RANGES = MAX_RANGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stream in
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [55:0]           s_axis_tdata_i,  // text_byte, range_slot, range_first, range_last
  input  logic [0:0]            s_axis_tuser_i,  // opcode
  // stream out
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [39:0]           m_axis_tdata_o,  // code_point, glyph_index, found, bad_lead, pad
  // config writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned OFS_W = SIZE_W + 1 + $clog2(MAX_RANGES);

  logic               adv, accept;
  logic [RC_W-1:0]    range_count_q;
  logic [GLYPH_W-1:0] glyph_total_q;

  tok_t                    tok   [MAX_RANGES+1];
  logic signed [OFS_W-1:0] ofs   [MAX_RANGES+1];

  logic               out_vld_q, out_vld_d;
  logic [CP_W-1:0]    out_cp_q;
  logic [GLYPH_W-1:0] out_glyph_q;
  logic               out_found_q, out_bad_q;
  tok_t               tail;

  // chain moves unless a finished word is stuck at the output
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_count_q <= '0;
      glyph_total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_COUNT: range_count_q <= cfg_data_i[RC_W-1:0];
        CFG_GLYPH_TOTAL: glyph_total_q <= cfg_data_i[GLYPH_W-1:0];
        default: ;
      endcase
    end
  end

  ugim_decoder u_dec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .accept_i      (accept),
    .opcode_i      (s_axis_tuser_i[0]),
    .text_byte_i   (s_axis_tdata_i[7:0]),
    .range_slot_i  (s_axis_tdata_i[13:8]),
    .range_first_i (s_axis_tdata_i[34:14]),
    .range_last_i  (s_axis_tdata_i[55:35]),
    .tok_o         (tok[0])
  );

  assign ofs[0] = '0;

  // chain of range cells, one per table slot
  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    ugim_cell #(
      .IDX   (g),
      .OFS_W (OFS_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .adv_i         (adv),
      .range_count_i (range_count_q),
      .glyph_total_i (glyph_total_q),
      .tok_i         (tok[g]),
      .ofs_i         (ofs[g]),
      .tok_o         (tok[g+1]),
      .ofs_o         (ofs[g+1])
    );
  end

  assign tail      = tok[MAX_RANGES];
  assign out_vld_d = adv ? (tail.vld && !tail.load) : out_vld_q;

  // output register, lookups only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_cp_q    <= tail.lo;
      out_glyph_q <= tail.glyph;
      out_found_q <= tail.found;
      out_bad_q   <= tail.bad;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_bad_q, out_found_q, out_glyph_q, out_cp_q};

  // a stalled output word blocks the input side
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  // a found index is always below the glyph count
  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_found_q) |-> (out_glyph_q < glyph_total_q))
    else $error("found index not below glyph count");

  // an invalid lead byte always yields code point zero
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_bad_q) |-> (out_cp_q == '0))
    else $error("bad lead with nonzero code point");

  // a miss reports glyph index zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_found_q) |-> (out_glyph_q == '0))
    else $error("miss with nonzero glyph index");

endmodule
